// ===== design/swms_pkg.sv =====
// Package for the sliding-window mean and standard deviation core.
// Holds the window size, derived widths, state encodings and the interface structs.
// Depends on nothing; every other design file imports it.
package swms_pkg;

    localparam int WINDOW   = 10;
    localparam int SAMPLE_W = 12;
    localparam int MEAN_W   = 16;
    localparam int STD_W    = 15;

    localparam longint SAMPLE_MAX = 64'd4095;

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = $clog2(SAMPLE_MAX * WINDOW + 1);
    localparam int SQ_W   = $clog2(SAMPLE_MAX * SAMPLE_MAX * WINDOW + 1);
    localparam int SS_W   = 2 * SUM_W;
    // N*Q bounds N*Q - S*S from above.
    localparam int NQ_W   = $clog2(SAMPLE_MAX * SAMPLE_MAX * WINDOW * WINDOW + 1);
    localparam int DF_W   = (NQ_W > SS_W) ? NQ_W : SS_W;
    // Radicand is 256*(N*Q - S*S), rounded up to whole bit pairs.
    localparam int RAD_W  = ((NQ_W + 8 + 1) / 2) * 2;
    localparam int ROOT_W = RAD_W / 2;
    localparam int MDIV_W = SUM_W + 4;
    localparam int DIV_W  = (MDIV_W > ROOT_W) ? MDIV_W : ROOT_W;
    localparam int DR_W   = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(ROOT_W);

    // Division by the window is a multiplication by a rounded-up reciprocal.
    // The rounding error stays below the window size, so the quotient is exact
    // for every dividend below 2**DIV_W.
    localparam int RECIP_SH = DIV_W + DR_W;
    localparam longint unsigned RECIP_M =
        ((64'd1 << RECIP_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam int RCP_W  = DIV_W + 2;
    localparam int PROD_W = DIV_W + RCP_W;

    localparam int IN_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((MEAN_W + STD_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_UPDATE,
        CORE_CALC
    } core_state_t;

    typedef enum logic [2:0] {
        STAT_IDLE,
        STAT_MUL,
        STAT_DIFF,
        STAT_ROOT,
        STAT_SDIV,
        STAT_DONE
    } stat_state_t;

    typedef struct packed {
        logic             valid;
        logic             ack;
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  sqsum;
    } stat_req_t;

    typedef struct packed {
        logic              valid;
        logic [MEAN_W-1:0] mean;
        logic [STD_W-1:0]  stddev;
    } stat_rsp_t;

endpackage

// ===== design/swms_stats.sv =====
// Statistics engine: turns the running sum and sum of squares into mean and deviation.
// Uses a bit-pair square root iteration and a reciprocal multiplication by the window size.
// Depends on swms_pkg.
module swms_stats
    import swms_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  stat_req_t req,
    output stat_rsp_t rsp
);

    stat_state_t state_reg, state_next;

    logic [SUM_W-1:0]  sum_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [SS_W-1:0]   ss_reg;
    logic [NQ_W-1:0]   nq_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [ROOT_W+1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [MEAN_W-1:0] mean_reg;
    logic [STD_W-1:0]  std_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic [DF_W-1:0]   diff;
    logic [ROOT_W+3:0] sq_cur;
    logic [ROOT_W+3:0] sq_trial;
    logic              sq_ge;
    logic [PROD_W-1:0] mean_prod;
    logic [PROD_W-1:0] std_prod;
    logic              cnt_last;

    assign diff      = DF_W'(nq_reg) - DF_W'(ss_reg);
    assign sq_cur    = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign sq_trial  = {2'b00, root_reg, 2'b01};
    assign sq_ge     = (sq_cur >= sq_trial);
    assign mean_prod = PROD_W'({sum_reg, 4'h0}) * PROD_W'(RECIP_M);
    assign std_prod  = PROD_W'(root_reg) * PROD_W'(RECIP_M);
    assign cnt_last  = (cnt_reg == CNT_W'(ROOT_W - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STAT_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rsp.valid  = 1'b0;
        rsp.mean   = mean_reg;
        rsp.stddev = std_reg;
        unique case (state_reg)
            STAT_IDLE:  if (req.valid) state_next = STAT_MUL;
            STAT_MUL:   state_next = STAT_DIFF;
            STAT_DIFF:  state_next = STAT_ROOT;
            STAT_ROOT:  if (cnt_last) state_next = STAT_SDIV;
            STAT_SDIV:  state_next = STAT_DONE;
            STAT_DONE:
            begin
                rsp.valid = 1'b1;
                if (req.ack) state_next = STAT_IDLE;
            end
            default:    state_next = STAT_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            STAT_IDLE:
            begin
                sum_reg <= req.sum;
                sq_reg  <= req.sqsum;
            end
            STAT_MUL:
            begin
                ss_reg <= SS_W'(sum_reg) * SS_W'(sum_reg);
                nq_reg <= NQ_W'(sq_reg) * NQ_W'(WINDOW);
            end
            STAT_DIFF:
            begin
                // The difference is never negative and always fits N*Q's width.
                rad_reg  <= RAD_W'({diff[NQ_W-1:0], 8'h00});
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
                mean_reg <= mean_prod[RECIP_SH +: MEAN_W];
            end
            STAT_ROOT:
            begin
                rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
                rem_reg  <= sq_ge ? (ROOT_W+2)'(sq_cur - sq_trial) : (ROOT_W+2)'(sq_cur);
                root_reg <= {root_reg[ROOT_W-2:0], sq_ge};
                cnt_reg  <= cnt_reg + CNT_W'(1);
            end
            STAT_SDIV:
            begin
                std_reg <= std_prod[RECIP_SH +: STD_W];
            end
            default:
            begin
            end
        endcase
    end

    // The root remainder never exceeds twice the partial root.
    a_root_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == STAT_ROOT) |=> (rem_reg <= (ROOT_W+2)'({root_reg, 1'b0})))
        else $error("square root remainder out of range");

    // The square root runs for exactly one step per root bit.
    a_root_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == STAT_ROOT) |-> ({1'b0, cnt_reg} < (CNT_W+1)'(ROOT_W)))
        else $error("square root step count out of range");

    // The mean never exceeds sixteen times the largest sample.
    a_mean_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == STAT_DONE) |-> (mean_reg <= MEAN_W'(16 * SAMPLE_MAX)))
        else $error("mean out of range");

    // A new request never arrives while a computation is in flight.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid |-> (state_reg == STAT_IDLE))
        else $error("statistics request while busy");

endmodule

// ===== design/sliding_window_mean_stddev_core.sv =====
// Top level of the sliding-window mean and standard deviation core.
// Holds the sample ring memory, the running totals and the output register.
// Depends on swms_pkg and swms_stats.
//
// Usage: each input beat on the s_ channel carries one 12-bit sample in
// s_tdata. Every sample yields exactly one output beat on the m_ channel,
// carrying the window mean times 16 and the population standard deviation
// times 16 in m_tdata, and a flag in m_tuser that is high once the window
// holds WINDOW samples. Before that the values are still produced, with the
// empty slots counted as zero.
// A sample is taken only when the core is idle. On the accepting edge the
// ring memory returns the oldest sample; the next cycle updates the totals
// and starts the statistics engine, which forms the products, then the
// difference and the mean, then the square root, one root bit per step,
// and finally divides the root by the window. The result is then offered
// on m_tvalid, and the core takes no new sample until that result has
// entered the output register.
// Reset clears the fill count, the write slot and both totals, so the window
// starts empty; the ring contents need no clearing. When the receiver stalls,
// the result waits in the output register and the core still accepts one
// more sample; that sample's result then waits in the engine until the
// output register is free.
module sliding_window_mean_stddev_core
    import swms_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [11:0] sample, rest zero
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [15:0] mean_x16, [30:16] std_x16, rest zero
    output logic                   m_tuser    // [0] window_full
);

    core_state_t state_reg, state_next;

    logic [SAMPLE_W-1:0]   ring_mem [WINDOW];
    logic [SAMPLE_W-1:0]   ring_q;

    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [SQ_W-1:0]       sq_reg, sq_next;
    logic [SAMPLE_W-1:0]   sample_reg;
    logic [2*SAMPLE_W-1:0] xsq_reg;

    logic                  out_valid_reg;
    logic [MEAN_W-1:0]     out_mean_reg;
    logic [STD_W-1:0]      out_std_reg;
    logic                  out_full_reg;

    logic                  in_beat;
    logic                  window_full;
    logic [SAMPLE_W-1:0]   old_sample;
    logic [2*SAMPLE_W-1:0] old_sq;
    logic                  out_free;
    logic                  out_load;

    stat_req_t sreq;
    stat_rsp_t srsp;

    assign s_tready    = (state_reg == CORE_IDLE);
    assign in_beat     = s_tvalid && s_tready;
    assign window_full = (fill_reg == FILL_W'(WINDOW));
    // The oldest sample leaves the totals only once the window is full.
    assign old_sample  = window_full ? ring_q : '0;
    assign old_sq      = (2*SAMPLE_W)'(old_sample) * (2*SAMPLE_W)'(old_sample);
    assign out_free    = !out_valid_reg || m_tready;
    assign out_load    = (state_reg == CORE_CALC) && srsp.valid && out_free;

    assign sum_next  = sum_reg - SUM_W'(old_sample) + SUM_W'(sample_reg);
    assign sq_next   = sq_reg - SQ_W'(old_sq) + SQ_W'(xsq_reg);
    assign slot_next = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + SLOT_W'(1);
    assign fill_next = window_full ? fill_reg : fill_reg + FILL_W'(1);

    assign sreq.valid = (state_reg == CORE_UPDATE);
    assign sreq.ack   = out_load;
    assign sreq.sum   = sum_next;
    assign sreq.sqsum = sq_next;

    swms_stats u_stats (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sreq),
        .rsp   (srsp)
    );

    // Ring memory: the read on the accepting edge returns the oldest sample,
    // and the new sample is written into the same slot in the update state that follows.
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            ring_q <= ring_mem[slot_reg];
        end
        if (state_reg == CORE_UPDATE)
        begin
            ring_mem[slot_reg] <= sample_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            sample_reg <= s_tdata[SAMPLE_W-1:0];
            xsq_reg    <= (2*SAMPLE_W)'(s_tdata[SAMPLE_W-1:0])
                          * (2*SAMPLE_W)'(s_tdata[SAMPLE_W-1:0]);
        end
        if (out_load)
        begin
            out_mean_reg <= srsp.mean;
            out_std_reg  <= srsp.stddev;
            out_full_reg <= window_full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CORE_IDLE;
            slot_reg      <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == CORE_UPDATE)
            begin
                slot_reg <= slot_next;
                fill_reg <= fill_next;
                sum_reg  <= sum_next;
                sq_reg   <= sq_next;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CORE_IDLE:   if (in_beat) state_next = CORE_UPDATE;
            CORE_UPDATE: state_next = CORE_CALC;
            CORE_CALC:   if (out_load) state_next = CORE_IDLE;
            default:     state_next = CORE_IDLE;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({out_std_reg, out_mean_reg});
    assign m_tuser  = out_full_reg;

    // The fill count saturates at the window size and the slot stays in range.
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg <= FILL_W'(WINDOW)) && (slot_reg <= SLOT_W'(WINDOW - 1)))
        else $error("fill count or write slot out of range");

    // Until the window fills, the write slot equals the number of samples held.
    a_fill_slot: assert property (@(posedge clk) disable iff (!rst_n)
        !window_full |-> (FILL_W'(slot_reg) == fill_reg))
        else $error("write slot and fill count disagree");

    // The running sum never exceeds a full window of largest samples.
    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CORE_UPDATE) |=> (sum_reg <= SUM_W'(SAMPLE_MAX * WINDOW)))
        else $error("running sum out of range");

    // Handing a result to the output register returns the core to idle and makes the output valid.
    a_load_after_calc: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (state_reg == CORE_IDLE) && out_valid_reg)
        else $error("result load did not complete");

endmodule
